FILE: design/bqd_pkg.sv
// Shared types and constants for the Bayer quad demosaic and white balance block.
`default_nettype none
package bqd_pkg;

  localparam int SIZE_W    = 15;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 12;
  localparam int GAIN_FRAC = 12;
  localparam logic [1:0] BEAT_LAST = 2'd3;

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_GAIN_RED  = 3'd2,
    REG_GAIN_BLUE = 3'd3,
    REG_MAX_VALUE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] green_top;
    logic [SAMPLE_W-1:0] green_bot;
    logic [COORD_W-1:0]  top_row;
    logic [COORD_W-1:0]  bot_row;
    logic [COORD_W-1:0]  col;
  } side_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] blue;
    side_t               side;
  } quad_t;

endpackage
`default_nettype wire

FILE: design/bqd_line_store.sv
// Even-row line store split into even-column and odd-column halves, registered read.
`default_nettype none
module bqd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_hi,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_lo,
  output logic [15:0]   rd_hi
);
  logic [15:0] mem_lo [DEPTH];
  logic [15:0] mem_hi [DEPTH];
  logic [15:0] rd_lo_r;
  logic [15:0] rd_hi_r;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_hi) begin
      mem_lo[wr_addr] <= wr_data;
    end
    if (wr_en && wr_hi) begin
      mem_hi[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= mem_lo[rd_addr];
      rd_hi_r <= mem_hi[rd_addr];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;
endmodule
`default_nettype wire

FILE: design/bqd_balance.sv
// Gain multiply stage for red and blue with truncation and clamp on the products.
`default_nettype none
module bqd_balance (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [15:0]   raw_red,
  input  logic [15:0]   raw_blue,
  input  logic [15:0]   gain_red,
  input  logic [15:0]   gain_blue,
  input  logic [15:0]   max_value,
  input  bqd_pkg::side_t side,
  input  logic          q_free,
  output logic          room,
  output logic          quad_valid,
  output bqd_pkg::quad_t quad
);
  import bqd_pkg::*;

  logic        s1_v_r;
  logic        s1_v_nxt;
  logic [31:0] prod_red_r;
  logic [31:0] prod_blue_r;
  side_t       side_r;

  function automatic logic [15:0] clamp_val(input logic [31:0] prod, input logic [15:0] maxv);
    logic [19:0] v;
    v = prod[31:GAIN_FRAC];
    if (v >= {4'd0, maxv}) begin
      return maxv - 16'd1;
    end
    return v[15:0];
  endfunction

  assign room = !s1_v_r || q_free;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_v_r && q_free) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_red_r  <= 32'(raw_red) * 32'(gain_red);
      prod_blue_r <= 32'(raw_blue) * 32'(gain_blue);
      side_r      <= side;
    end
  end

  assign quad_valid = s1_v_r;
  assign quad.red   = clamp_val(prod_red_r, max_value);
  assign quad.blue  = clamp_val(prod_blue_r, max_value);
  assign quad.side  = side_r;
endmodule
`default_nettype wire

FILE: design/bqd_quad_out.sv
// Output register that sends the four pixels of a quad as four beats.
`default_nettype none
module bqd_quad_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           quad_valid,
  input  bqd_pkg::quad_t quad,
  output logic           q_free,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [71:0]    out_tdata,
  output logic           out_tlast
);
  import bqd_pkg::*;

  logic        q_v_r;
  logic        q_v_nxt;
  logic [1:0]  k_r;
  logic [1:0]  k_nxt;
  quad_t       quad_r;
  logic        load;
  logic [15:0] green;
  logic [11:0] row;
  logic [11:0] col;

  assign q_free = !q_v_r || (k_r == BEAT_LAST && out_tready);
  assign load   = quad_valid && q_free;

  always_comb begin
    q_v_nxt = q_v_r;
    k_nxt   = k_r;
    if (load) begin
      q_v_nxt = 1'b1;
      k_nxt   = 2'd0;
    end else if (q_v_r && out_tready) begin
      if (k_r == BEAT_LAST) begin
        q_v_nxt = 1'b0;
        k_nxt   = 2'd0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
      k_r   <= 2'd0;
    end else begin
      q_v_r <= q_v_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quad_r <= quad;
    end
  end

  assign green = k_r[1] ? quad_r.side.green_bot : quad_r.side.green_top;
  assign row   = k_r[1] ? quad_r.side.bot_row : quad_r.side.top_row;
  assign col   = k_r[0] ? quad_r.side.col : {quad_r.side.col[11:1], 1'b0};

  assign out_tvalid = q_v_r;
  assign out_tdata  = {col, row, quad_r.blue, green, quad_r.red};
  assign out_tlast  = (k_r == BEAT_LAST);

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    !q_v_r |-> k_r == 2'd0)
    else $error("beat index nonzero while empty");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (q_v_r && k_r == BEAT_LAST && out_tready && !quad_valid) |=> !q_v_r)
    else $error("quad not released after last beat");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_v_r && out_tready && k_r != BEAT_LAST) |=> (q_v_r && k_r == $past(k_r) + 2'd1))
    else $error("beat index did not advance");
endmodule
`default_nettype wire

FILE: design/bayer_quad_demosaic_white_balance.sv
// Top level: counters, configuration registers, line store, gain stage and quad output.
// A completed quad is registered in the gain stage, then in the quad output register.
// Throughput: even rows take one sample per cycle; on odd rows the four-beat quad
// output sets the pace, and the sample that completes a quad waits for room.
// Reset: synchronous, active low; clears counters, left sample, valids and configuration
// registers to their defaults; the line store is not cleared and is written before it is read.
`default_nettype none
module bayer_quad_demosaic_white_balance #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // red, green, blue, out_row[11:0], out_col[11:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bqd_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [12:0]       width_r;
  logic [12:0]       height_r;
  logic [15:0]       gain_red_r;
  logic [15:0]       gain_blue_r;
  logic [15:0]       max_value_r;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     col_nxt;
  logic [RW-1:0]     row_r;
  logic [RW-1:0]     row_nxt;
  logic [15:0]       left_sample_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic [SIZE_W-1:0] top_diff;
  logic              row_in;
  logic              is_quad;
  logic              acc;
  logic              cfg_wr;
  logic [AW-1:0]     addr;
  logic              wr_en;
  logic              rd_en;
  logic [15:0]       rd_lo;
  logic [15:0]       rd_hi;
  logic              room;
  logic              quad_valid;
  logic              q_free;
  quad_t             quad;
  side_t             side;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 13'd4096;
      height_r    <= 13'd4096;
      gain_red_r  <= 16'd4096;
      gain_blue_r <= 16'd4096;
      max_value_r <= 16'd65535;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_WIDTH:     width_r     <= cfg_pwdata[12:0];
        REG_HEIGHT:    height_r    <= cfg_pwdata[12:0];
        REG_GAIN_RED:  gain_red_r  <= cfg_pwdata[15:0];
        REG_GAIN_BLUE: gain_blue_r <= cfg_pwdata[15:0];
        REG_MAX_VALUE: max_value_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_WIDTH:     cfg_prdata = {19'd0, width_r};
      REG_HEIGHT:    cfg_prdata = {19'd0, height_r};
      REG_GAIN_RED:  cfg_prdata = {16'd0, gain_red_r};
      REG_GAIN_BLUE: cfg_prdata = {16'd0, gain_blue_r};
      REG_MAX_VALUE: cfg_prdata = {16'd0, max_value_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_r == 13'd0) begin
      w_eff = SIZE_W'(1);
    end else if (SIZE_W'(width_r) > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = SIZE_W'(width_r);
    end
    if (height_r == 13'd0) begin
      h_eff = SIZE_W'(1);
    end else if (SIZE_W'(height_r) > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = SIZE_W'(height_r);
    end
  end

  assign row_in    = SIZE_W'(row_r) < h_eff;
  assign is_quad   = row_r[0] && col_r[0] && row_in;
  assign in_tready = !is_quad || room;
  assign acc       = in_tvalid && in_tready;

  assign col_inc = SIZE_W'(col_r) + SIZE_W'(1);
  assign row_inc = SIZE_W'(row_r) + SIZE_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      left_sample_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (row_r[0] && !col_r[0]) begin
        left_sample_r <= in_tdata;
      end
    end
  end

  assign addr  = AW'(col_r >> 1);
  assign wr_en = acc && !row_r[0];
  assign rd_en = acc && row_r[0] && !col_r[0];

  bqd_line_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_hi  (col_r[0]),
    .wr_addr(addr),
    .wr_data(in_tdata),
    .rd_en  (rd_en),
    .rd_addr(addr),
    .rd_lo  (rd_lo),
    .rd_hi  (rd_hi)
  );

  assign top_diff       = h_eff - SIZE_W'(row_r);
  assign side.green_top = rd_hi;
  assign side.green_bot = left_sample_r;
  assign side.top_row   = COORD_W'(top_diff);
  assign side.bot_row   = COORD_W'(top_diff - SIZE_W'(1));
  assign side.col       = COORD_W'(col_r);

  bqd_balance u_balance (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc && is_quad),
    .raw_red   (rd_lo),
    .raw_blue  (in_tdata),
    .gain_red  (gain_red_r),
    .gain_blue (gain_blue_r),
    .max_value (max_value_r),
    .side      (side),
    .q_free    (q_free),
    .room      (room),
    .quad_valid(quad_valid),
    .quad      (quad)
  );

  bqd_quad_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .quad_valid(quad_valid),
    .quad      (quad),
    .q_free    (q_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );
endmodule
`default_nettype wire

FILE: bench/bqd_quad_checker.sv
// Checker for the Bayer quad demosaic block: predicts quad pixels from input beats and compares.
module bqd_quad_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // red, green, blue, out_row[11:0], out_col[11:0]
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          error_count,
  output int          pixels_pending
);
  import bqd_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
  } pixel_t;

  pixel_t              pixel_q[$];
  logic [SAMPLE_W-1:0] line_store [MAX_WIDTH];
  logic [SAMPLE_W-1:0] left_px;
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  logic [12:0]         width_reg;
  logic [12:0]         height_reg;
  logic [15:0]         gain_r;
  logic [15:0]         gain_b;
  logic [15:0]         max_val;

  initial error_count = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned eff_size(logic [12:0] v, int unsigned lim);
    if (v == 13'd0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [15:0] balance(logic [15:0] raw, logic [15:0] gain);
    logic [31:0] prod;
    prod = 32'(raw) * 32'(gain);
    if ((prod >> GAIN_FRAC) >= max_val) return max_val - 16'd1;
    return prod[GAIN_FRAC +: SAMPLE_W];
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    case (reg_idx_t'(idx))
      REG_WIDTH:     width_reg  = value[12:0];
      REG_HEIGHT:    height_reg = value[12:0];
      REG_GAIN_RED:  gain_r     = value[15:0];
      REG_GAIN_BLUE: gain_b     = value[15:0];
      REG_MAX_VALUE: max_val    = value[15:0];
      default: ;
    endcase
  endtask

  task automatic take_sample(logic [15:0] s);
    int unsigned        w;
    int unsigned        h;
    logic [15:0]        r;
    logic [15:0]        b;
    logic [15:0]        g_top;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] bot_row;
    logic [COORD_W-1:0] c_left;
    logic [COORD_W-1:0] c_right;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (col_cnt < MAX_WIDTH) begin
      if (row_cnt[0] == 1'b0) begin
        line_store[col_cnt] = s;
      end else if (col_cnt[0] == 1'b0) begin
        left_px = s;
      end else if (row_cnt < h) begin
        r       = balance(line_store[col_cnt - 1], gain_r);
        b       = balance(s, gain_b);
        g_top   = line_store[col_cnt];
        top_row = COORD_W'(h - row_cnt);
        bot_row = COORD_W'(h - 1 - row_cnt);
        c_left  = COORD_W'(col_cnt - 1);
        c_right = COORD_W'(col_cnt);
        pixel_q.push_back('{r, g_top, b, top_row, c_left, 1'b0});
        pixel_q.push_back('{r, g_top, b, top_row, c_right, 1'b0});
        pixel_q.push_back('{r, left_px, b, bot_row, c_left, 1'b0});
        pixel_q.push_back('{r, left_px, b, bot_row, c_right, 1'b1});
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_q.size() == 0) begin
      report("beat with no pixel pending", out_tdata[31:0], 32'd0);
      return;
    end
    want = pixel_q.pop_front();
    if (out_tdata[15:0] !== want.red)    report("red", out_tdata[15:0], want.red);
    if (out_tdata[31:16] !== want.green) report("green", out_tdata[31:16], want.green);
    if (out_tdata[47:32] !== want.blue)  report("blue", out_tdata[47:32], want.blue);
    if (out_tdata[59:48] !== want.row)   report("out_row", out_tdata[59:48], want.row);
    if (out_tdata[71:60] !== want.col)   report("out_col", out_tdata[71:60], want.col);
    if (out_tlast !== want.last)         report("last", out_tlast, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 13'd4096;
      height_reg = 13'd4096;
      gain_r     = 16'd4096;
      gain_b     = 16'd4096;
      max_val    = 16'hFFFF;
      left_px    = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      pixel_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        write_reg(cfg_paddr[4:2], cfg_pwdata);
      end
      if (in_tvalid && in_tready) take_sample(in_tdata);
      if (out_tvalid && out_tready) check_pixel();
    end
    pixels_pending <= pixel_q.size();
  end

endmodule

FILE: bench/bayer_quad_demosaic_white_balance_tb.sv
// Testbench top for the Bayer quad demosaic block: drives frames and register writes.
module bayer_quad_demosaic_white_balance_tb;
  import bqd_pkg::*;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sample[15:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // red, green, blue, out_row[11:0], out_col[11:0]
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          error_count;
  int          pixels_pending;
  int          tx_gap_pct   = 25;
  int          rx_stall_pct = 79;
  bit          hold_off_req = 1'b0;
  int          random_items = 0;
  int unsigned frame_len    = 1;

  always #5 clk = ~clk;

  bayer_quad_demosaic_white_balance #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bqd_quad_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .error_count    (error_count),
    .pixels_pending (pixels_pending)
  );

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [12:0] v, int unsigned lim);
    if (v == 13'd0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd4096;
      3: return 16'($urandom_range(3000, 6000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_max();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(2, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] rand_dim(int unsigned typ);
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'($urandom_range(2, 40));
      default: return 13'($urandom_range(2, typ));
    endcase
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [12:0] w, logic [12:0] h, logic [15:0] gr,
                               logic [15:0] gb, logic [15:0] mx);
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    write_reg(REG_GAIN_RED, 32'(gr));
    write_reg(REG_GAIN_BLUE, 32'(gb));
    write_reg(REG_MAX_VALUE, 32'(mx));
    frame_len = clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT);
  endtask

  task automatic push_sample(logic [15:0] s);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every pending pixel, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frames(int frames);
    repeat (frames) begin
      for (int i = 0; i < frame_len; i++) push_sample(rand_sample());
    end
  endtask

  task automatic random_settings(int upto);
    int frames;
    while (random_items < upto) begin
      apply_setting(rand_dim(12), rand_dim(6), rand_gain(), rand_gain(), rand_max());
      frames = $urandom_range(1, 3);
      send_frames(frames);
      random_items += frames * frame_len;
      settle();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unity gains, samples at both extremes
    apply_setting(13'd2, 13'd2, 16'd4096, 16'd4096, 16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    settle();
    // odd width and height, zero clamp bound
    apply_setting(13'd3, 13'd3, 16'hFFFF, 16'd0, 16'd0);
    send_frames(1);
    settle();
    // zero size clamps to one
    apply_setting(13'd0, 13'd0, 16'd0, 16'hFFFF, 16'd1);
    send_frames(2);
    settle();
    apply_setting(13'd1, 13'd4, 16'd4096, 16'd4096, 16'hFFFF);
    send_frames(1);
    settle();

    random_settings(100);
    tx_gap_pct   = 79;
    rx_stall_pct = 25;
    random_settings(200);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    random_settings(300);

    // long receiver hold-off while the sender keeps offering beats
    apply_setting(13'd16, 13'd4, 16'hFFFF, 16'd1, 16'hFFFF);
    hold_off_req = 1'b1;
    send_frames(1);
    settle();

    if (error_count == 0 && pixels_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
